### rtl/core/mirfe_pkg.sv
// Shared constants, types and helper functions for the mouse input report front end.
// No dependencies; every other file in rtl/core imports this package.

package mirfe_pkg;

    // Number of debounced buttons and number of DPI presets.
    localparam int KEY_LANES        = 7;
    localparam int DPI_PRESET_COUNT = 5;

    // Fixed widths of the pin field and the configuration port.
    localparam int RAW_PIN_COUNT = 7;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_INDEX_W   = 1;

    // Button positions of the two DPI keys.
    localparam int BTN_DPI_UP   = 5;
    localparam int BTN_DPI_DOWN = 6;

    // The confirmed vector is padded to cover every pin position.
    localparam int CONF_W = (KEY_LANES > RAW_PIN_COUNT) ? KEY_LANES : RAW_PIN_COUNT;

    // Width of the internal preset index.
    localparam int IDX_W = (DPI_PRESET_COUNT > 2) ? $clog2(DPI_PRESET_COUNT) : 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SUSPEND_TICKS      = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [7:0]            DEBOUNCE_THRESHOLD_RST = 8'd5;
    localparam logic [CFG_DATA_W-1:0] SUSPEND_TICKS_RST      = 32'd60000;

    // Wheel step codes.
    localparam logic signed [1:0] WHEEL_NONE = 2'sb00;
    localparam logic signed [1:0] WHEEL_CCW  = 2'sb01;
    localparam logic signed [1:0] WHEEL_CW   = 2'sb11;

    // Resolution table in counts per inch.
    localparam int DPI_TABLE_LEN = 5;
    localparam logic [11:0] DPI_TABLE [DPI_TABLE_LEN] =
        '{12'd800, 12'd1200, 12'd1600, 12'd2400, 12'd3200};
    localparam logic [11:0] DPI_TOP_RES = 12'd3200;

    // DPI status handed from the preset stepper to the top level.
    typedef struct packed {
        logic [2:0]  index;
        logic [11:0] resolution;
        logic        changed;
    } dpi_res_t;

    function automatic logic [2:0] index_field(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[2:0];
    endfunction

    function automatic logic [11:0] resolution_of(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        if (wide < 32'(DPI_TABLE_LEN))
        begin
            return DPI_TABLE[wide[2:0]];
        end
        return DPI_TOP_RES;
    endfunction

endpackage

### rtl/core/mouse_input_report_front_end.sv
// Top level of the mouse input report front end: input and result registers,
// configuration registers, report change detection and the idle counter.
// Depends on mirfe_pkg, mirfe_debounce, mirfe_wheel and mirfe_dpi.

// One input word is one poll tick of the pins and the sensor deltas; each
// accepted word yields exactly one result word, in order. The block has a
// two-stage path: a word is captured in an input register, and once it moves on,
// the debounce lanes, the wheel decoder, the DPI stepper and the idle
// counter evaluate it in a single combinational pass and load the result
// register, updating their state at that same edge. A new word is accepted
// every clock cycle while the result side is not stalled, so the sustained
// rate is one word per cycle; the single pass through the 32-bit idle
// increment and suspend compare sets the clock.
// Ready is withdrawn only when both registers hold words and the result
// side is stalled. Configuration writes (debounce_threshold at index 0,
// suspend_ticks at index 1) take effect at once and must be issued only
// while no word is in flight. After reset the first tick only loads the
// wheel phase, the DPI preset index starts at one (1200 counts per inch),
// and the suspend flag rises once suspend_ticks consecutive ticks pass
// without a report; the idle count saturates at all ones.

module mouse_input_report_front_end (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [mirfe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mirfe_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Input channel.
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mirfe_pkg::RAW_PIN_COUNT-1:0] raw_buttons_n,
    input  logic                                wheel_phase_a,
    input  logic                                wheel_phase_b,
    input  logic                                motion_n,
    input  logic signed [15:0]                  sensor_dx,
    input  logic signed [15:0]                  sensor_dy,
    // Result channel.
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                report_valid,
    output logic [4:0]                          report_buttons,
    output logic signed [15:0]                  report_dx,
    output logic signed [15:0]                  report_dy,
    output logic signed [1:0]                   report_wheel,
    output logic [2:0]                          dpi_index,
    output logic [11:0]                         dpi_resolution,
    output logic                                dpi_changed,
    output logic                                suspended
);
    import mirfe_pkg::*;

    // Configuration registers.
    logic [7:0]            threshold_reg;
    logic [CFG_DATA_W-1:0] suspend_ticks_reg;

    // Input register stage.
    logic                     s1_valid_reg;
    logic [RAW_PIN_COUNT-1:0] s1_raw_reg;
    logic                     s1_pha_reg;
    logic                     s1_phb_reg;
    logic                     s1_motion_n_reg;
    logic signed [15:0]       s1_dx_reg;
    logic signed [15:0]       s1_dy_reg;

    // Result register stage.
    logic               out_valid_reg;
    logic               rpt_valid_reg;
    logic [4:0]         rpt_buttons_reg;
    logic signed [15:0] rpt_dx_reg;
    logic signed [15:0] rpt_dy_reg;
    logic signed [1:0]  rpt_wheel_reg;
    dpi_res_t           dpi_reg;
    logic               suspended_reg;

    // Report tracking state.
    logic [4:0]            last_buttons_reg;
    logic [CFG_DATA_W-1:0] idle_reg;
    logic [CFG_DATA_W-1:0] idle_next;

    logic               advance;
    logic [CONF_W-1:0]  confirmed;
    logic signed [1:0]  wheel;
    dpi_res_t           dpi_res;
    logic [4:0]         buttons5;
    logic signed [15:0] dx_masked;
    logic signed [15:0] dy_masked;
    logic               valid_now;
    logic               suspended_now;

    // The input word moves into the result register whenever that register
    // is empty or being drained in the same cycle.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg     <= DEBOUNCE_THRESHOLD_RST;
            suspend_ticks_reg <= SUSPEND_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE_THRESHOLD: threshold_reg     <= cfg_data[7:0];
                REG_SUSPEND_TICKS:      suspend_ticks_reg <= cfg_data;
                default:                threshold_reg     <= threshold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_raw_reg      <= raw_buttons_n;
            s1_pha_reg      <= wheel_phase_a;
            s1_phb_reg      <= wheel_phase_b;
            s1_motion_n_reg <= motion_n;
            s1_dx_reg       <= sensor_dx;
            s1_dy_reg       <= sensor_dy;
        end
    end

    mirfe_debounce u_debounce (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .threshold     (threshold_reg),
        .raw_buttons_n (s1_raw_reg),
        .confirmed     (confirmed)
    );

    mirfe_wheel u_wheel (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .wheel_phase_a (s1_pha_reg),
        .wheel_phase_b (s1_phb_reg),
        .wheel         (wheel)
    );

    mirfe_dpi u_dpi (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .dpi_up   (confirmed[BTN_DPI_UP]),
        .dpi_down (confirmed[BTN_DPI_DOWN]),
        .res      (dpi_res)
    );

    // Deltas only count when the sensor flags motion. A report goes out on
    // any wheel step, any button change or any nonzero delta.
    always_comb
    begin
        buttons5  = confirmed[4:0];
        dx_masked = s1_motion_n_reg ? 16'sd0 : s1_dx_reg;
        dy_masked = s1_motion_n_reg ? 16'sd0 : s1_dy_reg;
        valid_now = (wheel != WHEEL_NONE) || (buttons5 != last_buttons_reg)
                    || (dx_masked != 16'sd0) || (dy_masked != 16'sd0);
        if (valid_now)
        begin
            idle_next = '0;
        end
        else if (idle_reg != '1)
        begin
            idle_next = idle_reg + CFG_DATA_W'(1);
        end
        else
        begin
            idle_next = idle_reg;
        end
        suspended_now = (idle_next >= suspend_ticks_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_buttons_reg <= '0;
            idle_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                last_buttons_reg <= buttons5;
                idle_reg         <= idle_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rpt_valid_reg   <= valid_now;
            rpt_buttons_reg <= buttons5;
            rpt_dx_reg      <= dx_masked;
            rpt_dy_reg      <= dy_masked;
            rpt_wheel_reg   <= wheel;
            dpi_reg         <= dpi_res;
            suspended_reg   <= suspended_now;
        end
    end

    assign out_valid      = out_valid_reg;
    assign report_valid   = rpt_valid_reg;
    assign report_buttons = rpt_buttons_reg;
    assign report_dx      = rpt_dx_reg;
    assign report_dy      = rpt_dy_reg;
    assign report_wheel   = rpt_wheel_reg;
    assign dpi_index      = dpi_reg.index;
    assign dpi_resolution = dpi_reg.resolution;
    assign dpi_changed    = dpi_reg.changed;
    assign suspended      = suspended_reg;

`ifndef NO_ASSERTIONS
    // A report clears the idle count, so it cannot also flag suspend unless
    // the suspend threshold is zero.
    a_report_not_suspended: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && report_valid && (suspend_ticks_reg != '0)) |-> !suspended)
        else $error("top: suspend flagged together with a report");

    // A wheel step alone must always raise the report flag.
    a_wheel_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (report_wheel != WHEEL_NONE)) |-> report_valid)
        else $error("top: wheel step without report");

    // The wheel field only ever carries -1, 0 or +1.
    a_wheel_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (report_wheel != 2'sb10))
        else $error("top: illegal wheel code");
`endif

endmodule

### rtl/core/mirfe_debounce.sv
// Per-button saturating debounce counters and the confirmed button vector.
// Depends on mirfe_pkg.

module mirfe_debounce (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic [7:0]                          threshold,
    input  logic [mirfe_pkg::RAW_PIN_COUNT-1:0] raw_buttons_n,
    output logic [mirfe_pkg::CONF_W-1:0]        confirmed
);
    import mirfe_pkg::*;

    logic [7:0]           cnt_reg  [KEY_LANES];
    logic [7:0]           cnt_next [KEY_LANES];
    logic [KEY_LANES-1:0] conf_reg;
    logic [KEY_LANES-1:0] conf_next;
    logic [KEY_LANES-1:0] released;
    logic [CONF_W-1:0]    raw_ext;

    // Lanes without a pin read as released.
    always_comb
    begin
        raw_ext = '1;
        raw_ext[RAW_PIN_COUNT-1:0] = raw_buttons_n;
        released = raw_ext[KEY_LANES-1:0];
    end

    // One independent lane per button: a released sample clears at once,
    // pressed samples count up to the threshold and then confirm.
    always_comb
    begin
        for (int i = 0; i < KEY_LANES; i++)
        begin
            if (released[i])
            begin
                cnt_next[i]  = '0;
                conf_next[i] = 1'b0;
            end
            else
            begin
                cnt_next[i]  = (cnt_reg[i] < threshold) ? cnt_reg[i] + 8'd1 : cnt_reg[i];
                conf_next[i] = conf_reg[i] | (cnt_next[i] >= threshold);
            end
        end
    end

    always_comb
    begin
        confirmed = '0;
        confirmed[KEY_LANES-1:0] = conf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_LANES; i++)
            begin
                cnt_reg[i] <= '0;
            end
            conf_reg <= '0;
        end
        else if (step)
        begin
            for (int i = 0; i < KEY_LANES; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
            conf_reg <= conf_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A button sampled as released can never be confirmed right after.
    a_released_not_confirmed: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> ((conf_reg & $past(released)) == '0))
        else $error("debounce: released button left confirmed");
`endif

endmodule

### rtl/core/mirfe_wheel.sv
// Quadrature wheel decoder: compares the stored phase pair with the new one.
// Depends on mirfe_pkg.

module mirfe_wheel (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              wheel_phase_a,
    input  logic              wheel_phase_b,
    output logic signed [1:0] wheel
);
    import mirfe_pkg::*;

    logic [1:0] phase_reg;
    logic       primed_reg;
    logic [1:0] phase;
    logic [3:0] trans;

    assign phase = {wheel_phase_a, wheel_phase_b};
    assign trans = {phase_reg, phase};

    // Clockwise runs 00 > 01 > 11 > 10 > 00; the reverse order is counter-clockwise.
    always_comb
    begin
        wheel = WHEEL_NONE;
        if (primed_reg)
        begin
            if (trans inside {4'h1, 4'h7, 4'hE, 4'h8})
            begin
                wheel = WHEEL_CW;
            end
            else if (trans inside {4'h2, 4'hB, 4'hD, 4'h4})
            begin
                wheel = WHEEL_CCW;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            primed_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase;
            primed_reg <= 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    // Before the first sample has been loaded no step may be reported.
    a_unprimed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !primed_reg |-> (wheel == WHEEL_NONE))
        else $error("wheel: step reported before first phase sample");

    // Repeating the stored phase never produces a step.
    a_same_phase_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (phase == phase_reg) |-> (wheel == WHEEL_NONE))
        else $error("wheel: step reported without a phase change");
`endif

endmodule

### rtl/core/mirfe_dpi.sv
// DPI preset stepper: edge detection on the confirmed DPI keys and a wrapping index.
// Depends on mirfe_pkg.

module mirfe_dpi (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                dpi_up,
    input  logic                dpi_down,
    output mirfe_pkg::dpi_res_t res
);
    import mirfe_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DPI_PRESET_COUNT - 1);
    localparam logic [IDX_W-1:0] IDX_RESET = IDX_W'(1);

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_up;
    logic [IDX_W-1:0] idx_next;
    logic             up_prev_reg;
    logic             down_prev_reg;

    // Step up first, then step down, so both edges together cancel.
    always_comb
    begin
        idx_up = idx_reg;
        if (dpi_up && !up_prev_reg)
        begin
            idx_up = (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_W'(1);
        end
        idx_next = idx_up;
        if (dpi_down && !down_prev_reg)
        begin
            idx_next = (idx_up == '0) ? IDX_LAST : idx_up - IDX_W'(1);
        end
    end

    always_comb
    begin
        res.index      = index_field(idx_next);
        res.resolution = resolution_of(idx_next);
        res.changed    = (idx_next != idx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= IDX_RESET;
            up_prev_reg   <= 1'b0;
            down_prev_reg <= 1'b0;
        end
        else if (step)
        begin
            idx_reg       <= idx_next;
            up_prev_reg   <= dpi_up;
            down_prev_reg <= dpi_down;
        end
    end

`ifndef NO_ASSERTIONS
    // The index stays inside the preset table.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_LAST)
        else $error("dpi: preset index out of range");

    // Without a fresh key edge the index holds.
    a_no_edge_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !(dpi_up && !up_prev_reg) && !(dpi_down && !down_prev_reg))
        |=> (idx_reg == $past(idx_reg)))
        else $error("dpi: index moved without a key edge");
`endif

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the mouse input report front end.
// Depends on mirfe_pkg and mouse_input_report_front_end, which needs mirfe_debounce, mirfe_wheel and mirfe_dpi.

module tb;
    import mirfe_pkg::*;

    // Every key released: the pins are active low.
    localparam logic [RAW_PIN_COUNT-1:0] KEYS_UP = '1;
    // Wheel phase codes {A, B} in clockwise order; stepping backwards turns the wheel
    // counter-clockwise.
    localparam logic [1:0] GRAY_PHASE [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

    // One poll tick as it is offered on the input channel.
    typedef struct packed {
        logic [RAW_PIN_COUNT-1:0] keys_n;
        logic                     phase_a;
        logic                     phase_b;
        logic                     motion_n;
        logic signed [15:0]       dx;
        logic signed [15:0]       dy;
    } tick_t;

    // One report word as it should leave the result channel.
    typedef struct packed {
        logic               valid;
        logic [4:0]         buttons;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [1:0]  wheel;
        logic [2:0]         index;
        logic [11:0]        resolution;
        logic               changed;
        logic               suspend;
    } report_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [RAW_PIN_COUNT-1:0] raw_buttons_n = KEYS_UP;
    logic                     wheel_phase_a = 1'b0;
    logic                     wheel_phase_b = 1'b0;
    logic                     motion_n = 1'b1;
    logic signed [15:0]       sensor_dx = '0;
    logic signed [15:0]       sensor_dy = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     report_valid;
    logic [4:0]               report_buttons;
    logic signed [15:0]       report_dx;
    logic signed [15:0]       report_dy;
    logic signed [1:0]        report_wheel;
    logic [2:0]               dpi_index;
    logic [11:0]              dpi_resolution;
    logic                     dpi_changed;
    logic                     suspended;

    // Shadow of the block's state and registers, starting from their reset values.
    logic [7:0]               key_counts [RAW_PIN_COUNT] = '{default: 8'd0};
    logic [RAW_PIN_COUNT-1:0] keys_confirmed = '0;
    logic [1:0]               dpi_keys_prev = '0;
    logic [4:0]               buttons_reported = '0;
    logic [1:0]               phase_prev = '0;
    logic                     phase_loaded = 1'b0;
    logic [2:0]               preset_now = 3'd1;
    logic [31:0]              quiet_ticks = '0;
    logic [7:0]               cfg_threshold = DEBOUNCE_THRESHOLD_RST;
    logic [31:0]              cfg_suspend = SUSPEND_TICKS_RST;

    // Reports owed by the block, oldest first.
    report_t expected_reports [$];
    int      mismatches = 0;
    // When clear, neither side idles nor stalls.
    bit      gaps_on = 1'b1;

    // Random stimulus state: the held key pattern, the wheel position and quiet runs.
    logic [RAW_PIN_COUNT-1:0] held_keys = KEYS_UP;
    int                       hold_left = 0;
    int                       quiet_left = 0;
    int                       wheel_pos = 0;
    bit                       spin_cw = 1'b1;

    mouse_input_report_front_end dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .raw_buttons_n  (raw_buttons_n),
        .wheel_phase_a  (wheel_phase_a),
        .wheel_phase_b  (wheel_phase_b),
        .motion_n       (motion_n),
        .sensor_dx      (sensor_dx),
        .sensor_dy      (sensor_dy),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .report_valid   (report_valid),
        .report_buttons (report_buttons),
        .report_dx      (report_dx),
        .report_dy      (report_dy),
        .report_wheel   (report_wheel),
        .dpi_index      (dpi_index),
        .dpi_resolution (dpi_resolution),
        .dpi_changed    (dpi_changed),
        .suspended      (suspended)
    );

    always #5 clk = ~clk;

    // Advances the shadow state by one poll tick and queues the report it yields.
    // The order follows the block: wheel decode, debounce, DPI stepping, then
    // change detection and the idle counter.
    task automatic predict_report(input tick_t t);
        logic [1:0] phase;
        logic [3:0] turn;
        logic [1:0] dpi_keys;
        logic [2:0] old_preset;
        report_t    r;
        phase = {t.phase_a, t.phase_b};
        r.wheel = WHEEL_NONE;
        // The first tick after reset only loads the phase.
        if (phase_loaded)
        begin
            turn = {phase_prev, phase};
            case (turn)
                4'h1, 4'h7, 4'hE, 4'h8: r.wheel = WHEEL_CW;
                4'h2, 4'hB, 4'hD, 4'h4: r.wheel = WHEEL_CCW;
                default:                r.wheel = WHEEL_NONE;
            endcase
        end
        phase_prev = phase;
        phase_loaded = 1'b1;

        // A released sample drops a key at once; a pressed one counts up to the
        // threshold and confirms the key when the count gets there.
        for (int i = 0; i < RAW_PIN_COUNT; i++)
        begin
            if (t.keys_n[i])
            begin
                key_counts[i] = 8'd0;
                keys_confirmed[i] = 1'b0;
            end
            else
            begin
                if (key_counts[i] < cfg_threshold)
                    key_counts[i] = key_counts[i] + 8'd1;
                if (key_counts[i] >= cfg_threshold)
                    keys_confirmed[i] = 1'b1;
            end
        end

        // Rising edges of the confirmed DPI keys; up is applied before down, so
        // both in one tick cancel out.
        old_preset = preset_now;
        dpi_keys = {keys_confirmed[BTN_DPI_DOWN], keys_confirmed[BTN_DPI_UP]};
        if (dpi_keys[0] && !dpi_keys_prev[0])
            preset_now = (preset_now == 3'd4) ? 3'd0 : preset_now + 3'd1;
        if (dpi_keys[1] && !dpi_keys_prev[1])
            preset_now = (preset_now == 3'd0) ? 3'd4 : preset_now - 3'd1;
        dpi_keys_prev = dpi_keys;

        r.buttons = keys_confirmed[4:0];
        r.dx = t.motion_n ? 16'sd0 : t.dx;
        r.dy = t.motion_n ? 16'sd0 : t.dy;
        r.valid = (r.wheel != WHEEL_NONE) || (r.buttons != buttons_reported)
            || (r.dx != 16'sd0) || (r.dy != 16'sd0);
        buttons_reported = r.buttons;
        if (r.valid)
            quiet_ticks = '0;
        else if (quiet_ticks != '1)
            quiet_ticks = quiet_ticks + 32'd1;

        r.index = preset_now;
        case (preset_now)
            3'd0:    r.resolution = 12'd800;
            3'd1:    r.resolution = 12'd1200;
            3'd2:    r.resolution = 12'd1600;
            3'd3:    r.resolution = 12'd2400;
            default: r.resolution = 12'd3200;
        endcase
        r.changed = (preset_now != old_preset);
        r.suspend = (quiet_ticks >= cfg_suspend);
        expected_reports.push_back(r);
    endtask

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
            log_mismatch($sformatf("%s expected %0h, got %0h", field, want, got));
    endtask

    // Offers one word, idling before it at random, and waits for the handshake.
    // Valid is left high so that the next word follows without a gap.
    task automatic send_tick(input logic [RAW_PIN_COUNT-1:0] keys_n, input logic pa,
                             input logic pb, input logic mn,
                             input logic signed [15:0] dx, input logic signed [15:0] dy);
        tick_t t;
        t = '{keys_n: keys_n, phase_a: pa, phase_b: pb, motion_n: mn, dx: dx, dy: dy};
        if (gaps_on)
        begin
            while ($urandom_range(99) < 32)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid      <= 1'b1;
        raw_buttons_n <= t.keys_n;
        wheel_phase_a <= t.phase_a;
        wheel_phase_b <= t.phase_b;
        motion_n      <= t.motion_n;
        sensor_dx     <= t.dx;
        sensor_dy     <= t.dy;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_report(t);
    endtask

    // Stops offering words, waits until every owed report has arrived, and then
    // idles on to cover the two-stage path.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_DEBOUNCE_THRESHOLD)
            cfg_threshold = data[7:0];
        else if (idx == REG_SUSPEND_TICKS)
            cfg_suspend = data;
    endtask

    // Random ticks shaped so that keys are often held long enough to get through the
    // debounce, the wheel mostly turns in legal steps, and quiet runs let the
    // idle counter reach the suspend threshold.
    task automatic random_ticks(input int count);
        logic [RAW_PIN_COUNT-1:0] keys_n;
        logic                     mn;
        logic signed [15:0]       dx;
        logic signed [15:0]       dy;
        int                       pick;
        for (int n = 0; n < count; n++)
        begin
            if (hold_left == 0)
            begin
                held_keys = RAW_PIN_COUNT'($urandom);
                if ($urandom_range(1) != 0)
                    hold_left = int'(cfg_threshold) + $urandom_range(0, 8);
                else
                    hold_left = $urandom_range(1, int'(cfg_threshold) + 2);
            end
            else
                hold_left--;
            if (quiet_left == 0 && $urandom_range(99) < 4)
                quiet_left = $urandom_range(1, 24);

            keys_n = held_keys;
            if (quiet_left == 0)
            begin
                // A short glitch on some pins now and then.
                if ($urandom_range(99) < 3)
                    keys_n = held_keys ^ RAW_PIN_COUNT'($urandom);
                pick = $urandom_range(99);
                if (pick < 8)
                    spin_cw = !spin_cw;
                if (pick < 60)
                    wheel_pos = spin_cw ? (wheel_pos + 1) % 4 : (wheel_pos + 3) % 4;
                else if (pick < 75)
                    wheel_pos = $urandom_range(3);
                mn = 1'($urandom_range(1));
            end
            else
                mn = 1'b1;

            case ($urandom_range(9))
                0:       dx = 16'sh8000;
                1:       dx = 16'sh7FFF;
                2:       dx = 16'sd0;
                default: dx = 16'($urandom);
            endcase
            case ($urandom_range(9))
                0:       dy = 16'sh8000;
                1:       dy = 16'sh7FFF;
                2:       dy = 16'sd0;
                default: dy = 16'($urandom);
            endcase

            send_tick(keys_n, GRAY_PHASE[wheel_pos][1], GRAY_PHASE[wheel_pos][0], mn, dx, dy);
            if (quiet_left != 0)
                quiet_left--;
        end
    endtask

    // Reset registers: first-tick wheel load, both turning directions, illegal
    // jumps, delta extremes and the motion flag gating the deltas.
    task automatic test_wheel_and_motion();
        send_tick(KEYS_UP, 1'b1, 1'b1, 1'b0, 16'sh8000, 16'sh7FFF);
        send_tick(KEYS_UP, 1'b1, 1'b0, 1'b0, 16'sh7FFF, 16'sh8000);
        send_tick(KEYS_UP, 1'b0, 1'b0, 1'b1, 16'sd1234, -16'sd5);
        send_tick(KEYS_UP, 1'b0, 1'b1, 1'b0, 16'sd0, 16'sd0);
        send_tick(KEYS_UP, 1'b0, 1'b0, 1'b0, -16'sd1, 16'sd0);
        send_tick(KEYS_UP, 1'b1, 1'b0, 1'b1, 16'sd0, 16'sd7);
        send_tick(KEYS_UP, 1'b1, 1'b0, 1'b1, 16'sd0, 16'sd0);
        send_tick(KEYS_UP, 1'b0, 1'b1, 1'b1, 16'sd0, 16'sd0);
        settle();
    endtask

    // One-sample debounce: every key alone, all at once, DPI wrap at both ends
    // and both DPI keys rising together.
    task automatic test_keys_and_dpi();
        write_reg(REG_DEBOUNCE_THRESHOLD, 32'd1);
        send_tick(7'h00, 1'b0, 1'b1, 1'b1, 16'sd0, 16'sd0);
        send_tick(7'h7F, 1'b0, 1'b1, 1'b1, 16'sd0, 16'sd0);
        for (int i = 0; i < 4; i++)
        begin
            send_tick(7'h5F, 1'b0, 1'b1, 1'b1, 16'sd0, 16'sd0);
            send_tick(7'h7F, 1'b0, 1'b1, 1'b1, 16'sd0, 16'sd0);
        end
        send_tick(7'h3F, 1'b0, 1'b1, 1'b1, 16'sd0, 16'sd0);
        send_tick(7'h1F, 1'b0, 1'b1, 1'b1, 16'sd0, 16'sd0);
        for (int i = 0; i < 5; i++)
            send_tick(KEYS_UP ^ RAW_PIN_COUNT'(1 << i), 1'b0, 1'b1, 1'b0, 16'sd3, -16'sd3);
        settle();
    endtask

    // Threshold of one, left from the previous test, and suspend after a single idle tick.
    task automatic test_fast_suspend();
        write_reg(REG_SUSPEND_TICKS, 32'd1);
        random_ticks(180);
        settle();
    endtask

    task automatic test_moderate_settings();
        write_reg(REG_DEBOUNCE_THRESHOLD, 32'($urandom_range(2, 8)));
        write_reg(REG_SUSPEND_TICKS, 32'($urandom_range(2, 20)));
        random_ticks(300);
        settle();
    endtask

    // Largest threshold: keys are held for hundreds of ticks before they count.
    task automatic test_long_debounce();
        write_reg(REG_DEBOUNCE_THRESHOLD, 32'd255);
        write_reg(REG_SUSPEND_TICKS, 32'hFFFF_FFFF);
        random_ticks(300);
        settle();
    endtask

    // Back-to-back words with the result side always ready.
    task automatic test_full_rate();
        gaps_on = 1'b0;
        write_reg(REG_DEBOUNCE_THRESHOLD, 32'd3);
        write_reg(REG_SUSPEND_TICKS, 32'd12);
        random_ticks(150);
        settle();
        gaps_on = 1'b1;
    endtask

    // Result side: stalls at random, takes each report word and compares it
    // field by field with the oldest owed report.
    always @(posedge clk)
    begin : report_checker
        report_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                    log_mismatch("report word with none owed");
                else
                begin
                    want = expected_reports.pop_front();
                    compare_field("report_valid", want.valid, report_valid);
                    compare_field("report_buttons", want.buttons, report_buttons);
                    compare_field("report_dx", want.dx, report_dx);
                    compare_field("report_dy", want.dy, report_dy);
                    compare_field("report_wheel", want.wheel, report_wheel);
                    compare_field("dpi_index", want.index, dpi_index);
                    compare_field("dpi_resolution", want.resolution, dpi_resolution);
                    compare_field("dpi_changed", want.changed, dpi_changed);
                    compare_field("suspended", want.suspend, suspended);
                end
            end
            out_ready <= gaps_on ? ($urandom_range(99) >= 32) : 1'b1;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_wheel_and_motion();
        test_keys_and_dpi();
        test_fast_suspend();
        test_moderate_settings();
        test_long_debounce();
        test_full_rate();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this.
    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
rtl/core/mirfe_pkg.sv
rtl/core/mirfe_debounce.sv
rtl/core/mirfe_wheel.sv
rtl/core/mirfe_dpi.sv
rtl/core/mouse_input_report_front_end.sv
test/tb.sv
